/* rtl/core/grid_bfs_shortest_path_macros.svh */
// Assertion macros used by the RTL top level.
`ifndef GRID_BFS_SHORTEST_PATH_MACROS_SVH
`define GRID_BFS_SHORTEST_PATH_MACROS_SVH

// same-cycle implication, checked out of reset
`define GBFS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gbfs assertion failed");

// next-cycle implication, checked out of reset
`define GBFS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gbfs assertion failed");

`endif

/* rtl/core/gbfs_pkg.sv */
`timescale 1ns / 1ps
package gbfs_pkg;
	localparam int POS_W  = 6;
	localparam int STEP_W = 12;
	localparam int LEN_W  = 12;
	localparam int LEN_MAX = 4095;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_SOLVE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [1:0] KIND_FLOOR = 2'd0;
	localparam logic [1:0] KIND_WALL  = 2'd1;
	localparam logic [1:0] KIND_START = 2'd2;
	localparam logic [1:0] KIND_END   = 2'd3;

	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_RIGHT = 2'd1;
	localparam logic [1:0] DIR_DOWN  = 2'd2;
	localparam logic [1:0] DIR_LEFT  = 2'd3;

	localparam logic REPLY_SOLVE = 1'b0;
	localparam logic REPLY_MOVE  = 1'b1;

	typedef struct packed {
		logic [STEP_W-1:0] step;
		logic [1:0]        kind;
		logic [POS_W-1:0]  col;
		logic [POS_W-1:0]  row;
		logic [1:0]        cmd;
	} cmd_t;

	typedef struct packed {
		logic [1:0]       dir;
		logic [LEN_W-1:0] len;
		logic             reachable;
		logic             kind;
	} res_t;
endpackage

/* rtl/core/grid_bfs_shortest_path.sv */
`timescale 1ns / 1ps
// Load: no reply. Read: ST_RRD, then ST_RES, then the reply register drives m_tvalid.
// Solve: ST_CLR clears all MAX_ROWS*MAX_COLS visited entries, ST_CHK seeds the queue, then
// each dequeued cell has its in-grid neighbors checked and queued, then the path is
// backtracked from the end and ST_RES hands the reply on. One item at a time; input waits.
// arst_n clears control, grid size (64x64), positions, path length and found flag;
// memories hold no reset.
module grid_bfs_shortest_path #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// command item in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // command[1:0], cell_row[7:2], cell_col[13:8],
	                              // cell_kind[15:14], step_index[27:16], zero pad
	// reply item out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // reachable[0], path_length[12:1], move_dir[14:13], pad
	output logic        m_tuser,  // reply_kind[0]
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data
);
	localparam int RCW = $clog2(MAX_ROWS + 1);
	localparam int CCW = $clog2(MAX_COLS + 1);
	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	logic [RCW-1:0] row_cnt_q;
	logic [CCW-1:0] col_cnt_q;

	// active grid size, zero taken as one, large values clamp to the array size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q <= (MAX_ROWS < 64) ? RCW'(MAX_ROWS) : RCW'(64);
			col_cnt_q <= (MAX_COLS < 64) ? CCW'(MAX_COLS) : CCW'(64);
		end else if (cfg_we) begin
			if (cfg_index == REG_ROWS) begin
				if (cfg_data == '0) row_cnt_q <= RCW'(1);
				else if (32'(cfg_data) > MAX_ROWS) row_cnt_q <= RCW'(MAX_ROWS);
				else row_cnt_q <= RCW'(cfg_data);
			end
			if (cfg_index == REG_COLS) begin
				if (cfg_data == '0) col_cnt_q <= CCW'(1);
				else if (32'(cfg_data) > MAX_COLS) col_cnt_q <= CCW'(MAX_COLS);
				else col_cnt_q <= CCW'(cfg_data);
			end
		end
	end

	gbfs_pkg::cmd_t cmd;
	gbfs_pkg::res_t res;
	logic eng_idle, res_valid, res_take;
	logic m_valid_q;
	gbfs_pkg::res_t out_q;

	assign cmd = s_tdata[$bits(gbfs_pkg::cmd_t)-1:0];
	// engine takes an item only from idle; the reply register decouples the output
	assign s_tready = eng_idle;

	gbfs_engine #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.start(s_tvalid && s_tready),
		.cmd(cmd),
		.row_cnt(row_cnt_q),
		.col_cnt(col_cnt_q),
		.idle(eng_idle),
		.res_valid(res_valid),
		.res(res),
		.res_take(res_take)
	);

	// output register, refilled when empty or being drained
	assign res_take = res_valid && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_valid_q <= 1'b0;
		else if (res_take) m_valid_q <= 1'b1;
		else if (m_tready) m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_take) out_q <= res;
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser = out_q.kind;
	assign m_tdata = {1'b0, out_q.dir, out_q.len, out_q.reachable};

	logic rep_solve, rep_move;
	assign rep_solve = m_tvalid && m_tuser == gbfs_pkg::REPLY_SOLVE;
	assign rep_move = m_tvalid && m_tuser == gbfs_pkg::REPLY_MOVE;

`include "grid_bfs_shortest_path_macros.svh"

	// a solve reply with a nonzero length must report the end as reached
	`GBFS_ASSERT_NOW(a_len_needs_found, rep_solve && m_tdata[12:1] != '0, m_tdata[0])
	// a move reply before any path was found carries move up
	`GBFS_ASSERT_NOW(a_move_needs_found, rep_move && !m_tdata[0], m_tdata[14:13] == '0)
	// a solve item blocks the input in the following cycle
	`GBFS_ASSERT_NEXT(a_solve_blocks, s_tvalid && s_tready && cmd.cmd == gbfs_pkg::CMD_SOLVE, !s_tready)
endmodule

/* rtl/core/gbfs_engine.sv */
`timescale 1ns / 1ps
module gbfs_engine #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  gbfs_pkg::cmd_t                  cmd,
	input  logic [$clog2(MAX_ROWS+1)-1:0]   row_cnt,
	input  logic [$clog2(MAX_COLS+1)-1:0]   col_cnt,
	output logic                            idle,
	output logic                            res_valid,
	output gbfs_pkg::res_t                  res,
	input  logic                            res_take
);
	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int ADDR = $clog2(CELLS);
	localparam int QW = ADDR + 1;
	localparam int RW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_COLS);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CLR  = 4'd1;
	localparam logic [3:0] ST_CHK  = 4'd2;
	localparam logic [3:0] ST_POP  = 4'd3;
	localparam logic [3:0] ST_CUR  = 4'd4;
	localparam logic [3:0] ST_NRD  = 4'd5;
	localparam logic [3:0] ST_NCHK = 4'd6;
	localparam logic [3:0] ST_BREQ = 4'd7;
	localparam logic [3:0] ST_BUSE = 4'd8;
	localparam logic [3:0] ST_RRD  = 4'd9;
	localparam logic [3:0] ST_RES  = 4'd10;

	function automatic logic [ADDR-1:0] cell_addr(input logic [RW-1:0] r,
		input logic [CW-1:0] c);
		cell_addr = ADDR'(r) * ADDR'(MAX_COLS) + ADDR'(c);
	endfunction

	function automatic logic [gbfs_pkg::LEN_W-1:0] len_sat(input logic [ADDR-1:0] l);
		if (32'(l) > gbfs_pkg::LEN_MAX) len_sat = gbfs_pkg::LEN_W'(gbfs_pkg::LEN_MAX);
		else len_sat = gbfs_pkg::LEN_W'(32'(l));
	endfunction

	// memories
	logic                wall_mem [CELLS];
	logic [2:0]          vis_mem  [CELLS]; // {visited, arrival move}
	logic [RW+CW-1:0]    q_mem    [CELLS]; // {row, col}
	logic [1:0]          path_mem [CELLS]; // moves, end first

	logic                wall_we, wall_wd, wall_rd;
	logic [ADDR-1:0]     wall_wa, wall_ra;
	logic                vis_we;
	logic [2:0]          vis_wd, vis_rd;
	logic [ADDR-1:0]     vis_wa, vis_ra;
	logic                q_we;
	logic [RW+CW-1:0]    q_wd, q_rd;
	logic [ADDR-1:0]     q_wa, q_ra;
	logic                path_we;
	logic [1:0]          path_wd, path_rd;
	logic [ADDR-1:0]     path_wa, path_ra;

	always_ff @(posedge clk) begin
		if (wall_we) wall_mem[wall_wa] <= wall_wd;
		wall_rd <= wall_mem[wall_ra];
	end
	always_ff @(posedge clk) begin
		if (vis_we) vis_mem[vis_wa] <= vis_wd;
		vis_rd <= vis_mem[vis_ra];
	end
	always_ff @(posedge clk) begin
		if (q_we) q_mem[q_wa] <= q_wd;
		q_rd <= q_mem[q_ra];
	end
	always_ff @(posedge clk) begin
		if (path_we) path_mem[path_wa] <= path_wd;
		path_rd <= path_mem[path_ra];
	end

	// control state
	logic [3:0]                st_q;
	logic [gbfs_pkg::POS_W-1:0] srow_q, scol_q, erow_q, ecol_q;
	logic                      found_q, hit_q;
	logic [ADDR-1:0]           len_q, clr_q, k_q;
	logic [QW-1:0]             head_q, tail_q;
	logic [RW-1:0]             cur_r_q, nb_r_q, bt_r_q;
	logic [CW-1:0]             cur_c_q, nb_c_q, bt_c_q;
	logic [1:0]                dir_q;
	gbfs_pkg::res_t            res_q;

	// neighbor of the current cell in direction dir_q
	logic           nb_ok;
	logic [RW-1:0]  nb_r;
	logic [CW-1:0]  nb_c;
	always_comb begin
		nb_r = cur_r_q;
		nb_c = cur_c_q;
		nb_ok = 1'b0;
		case (dir_q)
			gbfs_pkg::DIR_UP: begin
				nb_ok = cur_r_q != '0;
				nb_r = cur_r_q - RW'(1);
			end
			gbfs_pkg::DIR_RIGHT: begin
				nb_ok = (32'(cur_c_q) + 32'd1) < 32'(col_cnt);
				nb_c = cur_c_q + CW'(1);
			end
			gbfs_pkg::DIR_DOWN: begin
				nb_ok = (32'(cur_r_q) + 32'd1) < 32'(row_cnt);
				nb_r = cur_r_q + RW'(1);
			end
			default: begin
				nb_ok = cur_c_q != '0;
				nb_c = cur_c_q - CW'(1);
			end
		endcase
	end

	logic in_range, load_ok, at_start;
	logic [RW-1:0] srow, erow;
	logic [CW-1:0] scol, ecol;
	logic [gbfs_pkg::LEN_W-1:0] len_cur;
	always_comb begin
		srow = RW'(srow_q);
		scol = CW'(scol_q);
		erow = RW'(erow_q);
		ecol = CW'(ecol_q);
		in_range = 32'(srow_q) < 32'(row_cnt) && 32'(scol_q) < 32'(col_cnt) &&
			32'(erow_q) < 32'(row_cnt) && 32'(ecol_q) < 32'(col_cnt);
		load_ok = 32'(cmd.row) < MAX_ROWS && 32'(cmd.col) < MAX_COLS;
		at_start = bt_r_q == srow && bt_c_q == scol;
		len_cur = len_sat(len_q);
	end

	// memory port control
	always_comb begin
		wall_we = 1'b0;
		wall_wa = cell_addr(RW'(cmd.row), CW'(cmd.col));
		wall_wd = cmd.kind == gbfs_pkg::KIND_WALL;
		wall_ra = cell_addr(nb_r, nb_c);
		vis_we = 1'b0;
		vis_wa = clr_q;
		vis_wd = 3'b000;
		vis_ra = cell_addr(nb_r, nb_c);
		q_we = 1'b0;
		q_wa = tail_q[ADDR-1:0];
		q_wd = {nb_r_q, nb_c_q};
		q_ra = head_q[ADDR-1:0];
		path_we = 1'b0;
		path_wa = k_q;
		path_wd = vis_rd[1:0];
		path_ra = ADDR'(32'(len_q) - 32'd1 - 32'(cmd.step));
		case (st_q)
			ST_IDLE: wall_we = start && cmd.cmd == gbfs_pkg::CMD_LOAD && load_ok;
			ST_CLR: vis_we = 1'b1;
			ST_CHK: begin
				vis_we = in_range;
				vis_wa = cell_addr(srow, scol);
				vis_wd = 3'b100;
				q_we = in_range;
				q_wa = '0;
				q_wd = {srow, scol};
			end
			ST_NCHK: begin
				vis_we = !vis_rd[2] && !wall_rd;
				vis_wa = cell_addr(nb_r_q, nb_c_q);
				vis_wd = {1'b1, dir_q};
				q_we = !vis_rd[2] && !wall_rd;
			end
			ST_BREQ: vis_ra = cell_addr(bt_r_q, bt_c_q);
			ST_BUSE: path_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			srow_q <= '0;
			scol_q <= '0;
			erow_q <= '0;
			ecol_q <= '0;
			found_q <= 1'b0;
			len_q <= '0;
			clr_q <= '0;
			k_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			dir_q <= '0;
			hit_q <= 1'b0;
			cur_r_q <= '0;
			cur_c_q <= '0;
			nb_r_q <= '0;
			nb_c_q <= '0;
			bt_r_q <= '0;
			bt_c_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: if (start) begin
					case (cmd.cmd)
						gbfs_pkg::CMD_LOAD: if (load_ok) begin
							if (cmd.kind == gbfs_pkg::KIND_START) begin
								srow_q <= cmd.row;
								scol_q <= cmd.col;
							end
							if (cmd.kind == gbfs_pkg::KIND_END) begin
								erow_q <= cmd.row;
								ecol_q <= cmd.col;
							end
						end
						gbfs_pkg::CMD_SOLVE: begin
							clr_q <= '0;
							k_q <= '0;
							st_q <= ST_CLR;
						end
						gbfs_pkg::CMD_READ: begin
							hit_q <= found_q && (cmd.step < len_cur);
							st_q <= ST_RRD;
						end
						default: ;
					endcase
				end
				ST_CLR: begin
					clr_q <= clr_q + ADDR'(1);
					if (32'(clr_q) == CELLS - 1) st_q <= ST_CHK;
				end
				ST_CHK: begin
					head_q <= '0;
					tail_q <= QW'(1);
					k_q <= '0;
					if (in_range) st_q <= ST_POP;
					else begin
						found_q <= 1'b0;
						len_q <= '0;
						st_q <= ST_RES;
					end
				end
				ST_POP: begin
					if (head_q < tail_q) begin
						head_q <= head_q + QW'(1);
						st_q <= ST_CUR;
					end else begin
						found_q <= 1'b0;
						len_q <= '0;
						st_q <= ST_RES;
					end
				end
				ST_CUR: begin
					cur_r_q <= q_rd[RW+CW-1:CW];
					cur_c_q <= q_rd[CW-1:0];
					bt_r_q <= q_rd[RW+CW-1:CW];
					bt_c_q <= q_rd[CW-1:0];
					dir_q <= gbfs_pkg::DIR_UP;
					if (q_rd == {erow, ecol}) st_q <= ST_BREQ;
					else st_q <= ST_NRD;
				end
				ST_NRD: begin
					nb_r_q <= nb_r;
					nb_c_q <= nb_c;
					if (nb_ok) st_q <= ST_NCHK;
					else if (dir_q == gbfs_pkg::DIR_LEFT) st_q <= ST_POP;
					else dir_q <= dir_q + 2'd1;
				end
				ST_NCHK: begin
					if (!vis_rd[2] && !wall_rd) tail_q <= tail_q + QW'(1);
					if (dir_q == gbfs_pkg::DIR_LEFT) st_q <= ST_POP;
					else begin
						dir_q <= dir_q + 2'd1;
						st_q <= ST_NRD;
					end
				end
				ST_BREQ: begin
					if (at_start) begin
						found_q <= 1'b1;
						len_q <= k_q;
						st_q <= ST_RES;
					end else st_q <= ST_BUSE;
				end
				ST_BUSE: begin
					k_q <= k_q + ADDR'(1);
					// step back against the arrival move
					case (vis_rd[1:0])
						gbfs_pkg::DIR_UP:    bt_r_q <= bt_r_q + RW'(1);
						gbfs_pkg::DIR_RIGHT: bt_c_q <= bt_c_q - CW'(1);
						gbfs_pkg::DIR_DOWN:  bt_r_q <= bt_r_q - RW'(1);
						default:             bt_c_q <= bt_c_q + CW'(1);
					endcase
					st_q <= ST_BREQ;
				end
				ST_RRD: st_q <= ST_RES;
				ST_RES: if (res_take) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (st_q == ST_RRD) begin
			res_q.kind <= gbfs_pkg::REPLY_MOVE;
			res_q.reachable <= found_q;
			res_q.len <= len_cur;
			res_q.dir <= hit_q ? path_rd : gbfs_pkg::DIR_UP;
		end else if (st_q != ST_RES) begin
			res_q.kind <= gbfs_pkg::REPLY_SOLVE;
			res_q.reachable <= st_q == ST_BREQ;
			res_q.len <= len_sat(k_q);
			res_q.dir <= gbfs_pkg::DIR_UP;
		end
	end

	assign idle = st_q == ST_IDLE;
	assign res_valid = st_q == ST_RES;
	assign res = res_q;
endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
	import gbfs_pkg::*;

	localparam int  CLK_HALF   = 5;
	localparam int  GRID_DIM   = 64;
	localparam int  CELL_TOTAL = GRID_DIM * GRID_DIM;
	localparam int  CYCLE_LIMIT = 4000000;
	localparam int  DRAIN_CYCLES = 40;
	localparam int  LONG_HOLD = 300;
	localparam int  RANDOM_ITEMS = 560;
	localparam bit  REG_ROWS = 1'b0;
	localparam bit  REG_COLS = 1'b1;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Scoreboard: mirrors the grid, runs its own search per solve and queues
	// the replies the block owes, in order.
	class path_scoreboard;
		bit         wall[CELL_TOTAL];
		bit         loaded[CELL_TOTAL];
		logic [1:0] moves[CELL_TOTAL];
		int         rows, cols;
		int         start_r, start_c, end_r, end_c;
		int         plen;
		bit         found;
		res_t       replies_due[$];
		int         errors;

		function new();
			rows = GRID_DIM;
			cols = GRID_DIM;
			start_r = 0; start_c = 0; end_r = 0; end_c = 0;
			plen = 0; found = 0; errors = 0;
		endfunction

		// out of range values clamp to 1..64
		function void set_reg(bit idx, logic [6:0] v);
			int n;
			n = (v == 0) ? 1 : ((v > GRID_DIM) ? GRID_DIM : int'(v));
			if (idx == REG_ROWS) rows = n;
			else cols = n;
		endfunction

		function int step_row(logic [1:0] d);
			return (d == DIR_UP) ? -1 : ((d == DIR_DOWN) ? 1 : 0);
		endfunction

		function int step_col(logic [1:0] d);
			return (d == DIR_RIGHT) ? 1 : ((d == DIR_LEFT) ? -1 : 0);
		endfunction

		function void solve_grid();
			bit         seen[CELL_TOTAL];
			logic [1:0] came[CELL_TOTAL];
			int         fifo[$];
			logic [1:0] rev[$];
			int         cur, goal, origin, nr, nc, nx, at;
			found = 0;
			plen = 0;
			if (start_r >= rows || start_c >= cols || end_r >= rows || end_c >= cols)
				return;
			goal = end_r * GRID_DIM + end_c;
			origin = start_r * GRID_DIM + start_c;
			fifo = {fifo, origin};
			seen[origin] = 1;
			while (fifo.size() != 0) begin
				cur = fifo.pop_front();
				if (cur == goal) break;
				for (int d = 0; d < 4; d++) begin
					nr = cur / GRID_DIM + step_row(d[1:0]);
					nc = cur % GRID_DIM + step_col(d[1:0]);
					if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
					nx = nr * GRID_DIM + nc;
					if (seen[nx] || wall[nx]) continue;
					seen[nx] = 1;
					came[nx] = d[1:0];
					fifo = {fifo, nx};
				end
			end
			if (!seen[goal]) return;
			found = 1;
			// walk back from the goal, collecting moves last-first
			at = goal;
			while (at != origin) begin
				rev.push_front(came[at]);
				at = (at / GRID_DIM - step_row(came[at])) * GRID_DIM
					+ (at % GRID_DIM - step_col(came[at]));
			end
			foreach (rev[k]) moves[k] = rev[k];
			plen = (rev.size() > LEN_MAX) ? LEN_MAX : rev.size();
		endfunction

		function void note_command(cmd_t c);
			res_t r;
			int cell_ix;
			case (c.cmd)
				CMD_LOAD: begin
					cell_ix = int'(c.row) * GRID_DIM + int'(c.col);
					wall[cell_ix] = (c.kind == KIND_WALL);
					loaded[cell_ix] = 1;
					if (c.kind == KIND_START) begin
						start_r = int'(c.row); start_c = int'(c.col);
					end
					if (c.kind == KIND_END) begin
						end_r = int'(c.row); end_c = int'(c.col);
					end
				end
				CMD_SOLVE: begin
					solve_grid();
					r.kind = REPLY_SOLVE;
					r.reachable = found;
					r.len = plen[LEN_W-1:0];
					r.dir = DIR_UP;
					replies_due = {replies_due, r};
				end
				CMD_READ: begin
					r.kind = REPLY_MOVE;
					r.reachable = found;
					r.len = plen[LEN_W-1:0];
					r.dir = (found && int'(c.step) < plen) ? moves[c.step] : DIR_UP;
					replies_due = {replies_due, r};
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			$display("MISMATCH @%0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_reply(logic kind, logic [15:0] d);
			res_t e;
			if (replies_due.size() == 0) begin
				report("reply with nothing outstanding");
				return;
			end
			e = replies_due.pop_front();
			if (kind !== e.kind)
				report($sformatf("reply_kind got %0b want %0b", kind, e.kind));
			if (d[0] !== e.reachable)
				report($sformatf("reachable got %0b want %0b", d[0], e.reachable));
			if (d[12:1] !== e.len)
				report($sformatf("path_length got %0d want %0d", d[12:1], e.len));
			if (d[14:13] !== e.dir)
				report($sformatf("move_dir got %0d want %0d", d[14:13], e.dir));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tuser;
	logic        cfg_we;
	logic        cfg_index;
	logic [6:0]  cfg_data;

	path_scoreboard sb;
	bit idle_on;         // random gaps on both sides
	bit long_hold_req;   // sink: request one long hold-off of m_tready
	bit hold_done;
	int items_sent;
	int cycles;

	grid_bfs_shortest_path u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		idle_on = 1'b1;
		long_hold_req = 1'b0;
		hold_done = 1'b0;
		items_sent = 0;
		cycles = 0;
		sb = new();
	end

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	// Reply sink: check on handshake, then pick next tready. Long hold is
	// counted here so the sender keeps pushing and the block backs up.
	int hold_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_reply(m_tuser, m_tdata);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				gap_left = $urandom_range(1, 19) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// one command item; waits for acceptance, maybe idles afterwards
	task automatic send_item(logic [1:0] cmd, int row, int col, logic [1:0] kind, int step);
		cmd_t c;
		c.cmd = cmd;
		c.row = row[POS_W-1:0];
		c.col = col[POS_W-1:0];
		c.kind = kind;
		c.step = step[STEP_W-1:0];
		s_tdata <= {4'b0, c};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_command(c);
		if (cmd != CMD_UNUSED) items_sent++;
		if (idle_on && $urandom_range(0, 9) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// stop sending, let every reply land, then cover load latency
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.replies_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(bit idx, logic [6:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		sb.set_reg(idx, v);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// new grid size, every active cell loaded, start and end placed
	task automatic build_maze(int rv, int cv, int wall_pct);
		drain();
		cfg_write(REG_ROWS, rv[6:0]);
		cfg_write(REG_COLS, cv[6:0]);
		for (int r = 0; r < sb.rows; r++)
			for (int c = 0; c < sb.cols; c++)
				send_item(CMD_LOAD, r, c,
					($urandom_range(0, 99) < wall_pct) ? KIND_WALL : KIND_FLOOR, 0);
		send_item(CMD_LOAD, $urandom_range(0, sb.rows - 1), $urandom_range(0, sb.cols - 1),
			KIND_START, $urandom);
		send_item(CMD_LOAD, $urandom_range(0, sb.rows - 1), $urandom_range(0, sb.cols - 1),
			KIND_END, $urandom);
	endtask

	// solve, then read the whole path plus a few random steps
	task automatic solve_and_walk(int extra);
		// never let the search touch a cell nobody wrote
		for (int r = 0; r < sb.rows; r++)
			for (int c = 0; c < sb.cols; c++)
				if (!sb.loaded[r * GRID_DIM + c])
					send_item(CMD_LOAD, r, c, KIND_FLOOR, 0);
		send_item(CMD_SOLVE, $urandom_range(0, 63), $urandom_range(0, 63), 2'($urandom),
			$urandom);
		for (int k = 0; k < sb.plen; k++)
			send_item(CMD_READ, $urandom_range(0, 63), $urandom_range(0, 63), 2'($urandom), k);
		repeat (extra)
			send_item(CMD_READ, 0, 0, KIND_FLOOR,
				$urandom_range(0, 1) ? $urandom_range(0, 4095) : sb.plen + $urandom_range(0, 2));
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: fresh reset, start and end both at 0,0; read before any path
		send_item(CMD_READ, 0, 0, KIND_FLOOR, 0);
		send_item(CMD_SOLVE, 0, 0, KIND_FLOOR, 0);
		send_item(CMD_READ, 63, 63, KIND_END, 4095);
		send_item(CMD_UNUSED, 63, 63, KIND_END, 4095);

		// single row, columns clamp from 127 down to 64; open line, long path
		build_maze(0, 127, 0);
		send_item(CMD_LOAD, 0, 0, KIND_START, 0);
		send_item(CMD_LOAD, 0, 63, KIND_END, 0);
		solve_and_walk(2);

		// start placed on a wall: search still begins there
		send_item(CMD_LOAD, 0, 0, KIND_WALL, 0);
		solve_and_walk(1);
		// start equals end
		send_item(CMD_LOAD, 0, 0, KIND_END, 0);
		solve_and_walk(1);

		// single column of 64, end walled off: unreachable
		build_maze(127, 1, 0);
		send_item(CMD_LOAD, 63, 0, KIND_START, 0);
		send_item(CMD_LOAD, 0, 0, KIND_END, 0);
		send_item(CMD_LOAD, 10, 0, KIND_WALL, 0);
		solve_and_walk(1);

		// end outside the active grid after shrinking to 1x1
		send_item(CMD_LOAD, 40, 0, KIND_END, 0);
		drain();
		cfg_write(REG_ROWS, 7'd1);
		solve_and_walk(1);

		// random mazes; reply side held off once while reads pile up
		while (items_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0)
				build_maze($urandom_range(0, 127), $urandom_range(1, 3), $urandom_range(0, 30));
			else
				build_maze($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(0, 40));
			if (!hold_done && items_sent > RANDOM_ITEMS / 2) begin
				long_hold_req = 1'b1;
				hold_done = 1'b1;
			end
			solve_and_walk($urandom_range(0, 3));
			// noise: stray loads, off-path reads, unused command
			repeat ($urandom_range(0, 3)) begin
				case ($urandom_range(0, 2))
					0: send_item(CMD_LOAD, $urandom_range(0, 63), $urandom_range(0, 63),
						2'($urandom), $urandom);
					1: send_item(CMD_READ, $urandom_range(0, 63), $urandom_range(0, 63),
						2'($urandom), $urandom_range(0, 4095));
					default: send_item(CMD_UNUSED, $urandom_range(0, 63),
						$urandom_range(0, 63), 2'($urandom), $urandom);
				endcase
			end
			// stale solve on the same grid, start moved inside it
			if ($urandom_range(0, 3) == 0) begin
				send_item(CMD_LOAD, $urandom_range(0, sb.rows - 1),
					$urandom_range(0, sb.cols - 1), KIND_START, 0);
				solve_and_walk(1);
			end
		end

		// tail: no idling, a few small grids
		drain();
		idle_on = 1'b0;
		repeat (3) begin
			build_maze($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(0, 30));
			solve_and_walk(2);
		end

		drain();
		if (sb.errors == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end
endmodule
